// ===== sv/double_hash_key_value_table_macros.svh =====
// Assertion macros for the key/value table; empty under synthesis.
`ifndef DOUBLE_HASH_KEY_VALUE_TABLE_MACROS_SVH
`define DOUBLE_HASH_KEY_VALUE_TABLE_MACROS_SVH

`ifndef SYNTHESIS

`define DHKV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dhkv assertion failed");

`define DHKV_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("dhkv assertion failed");

`else

`define DHKV_ASSERT(lbl, prop)
`define DHKV_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== sv/dhkv_pkg.sv =====
package dhkv_pkg;

    localparam int DEF_LOG_ENTRIES = 10;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_VALUE_BITS  = 64;

    localparam logic [3:0] LOG2_SIZE_RESET = 4'd10;

    // request op codes
    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_INSERT = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // cell tag in the top two bits of a cell word
    localparam logic [1:0] TAG_ENTRY   = 2'b00;
    localparam logic [1:0] TAG_EMPTY   = 2'b01;
    localparam logic [1:0] TAG_DELETED = 2'b10;

    localparam int LIVE_W = 11;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL_RD,
        S_CELL_CHK,
        S_KEY_CHK,
        S_ACT,
        S_RESP
    } t_state;

endpackage

// ===== sv/double_hash_key_value_table.sv =====
// Key/value table, open addressing with double hashing.
// Request channel (s_axis): tuser = op, tdata = key, key_hash, value.
// Result channel (m_axis): one beat per request with found, value_out,
// status and live_count. Config: i_cfg_we/i_cfg_wdata write the log2 size;
// every write empties the table.
// One request at a time. The probe walks cells from the top hash
// bits with stride 2*hash+1; each visited cell takes a cell RAM read state
// and a check state, plus a key RAM compare state when the cell holds an
// entry that is not yet matched. After the first empty cell, an action
// state and a result state follow. Ops 6 and 7 go straight to the result
// state. s_axis_tready comes back once the result state is left.
// Clear, reset and size writes run a sweep of 2 << L cells (2048 at L=10),
// one cell per cycle, with s_axis_tready low; a clear's beat follows it.
// The result sits in an output register; if the receiver stalls, the next
// request is still accepted and runs up to its result state, where it waits
// until the pending beat is taken.
`include "double_hash_key_value_table_macros.svh"

module double_hash_key_value_table
    import dhkv_pkg::*;
#(
    parameter int LOG_ENTRIES = DEF_LOG_ENTRIES,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_wdata,      // table_log2_size
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,     // key[31:0], key_hash[63:32], value[127:64]
    input  logic [2:0]   s_axis_tuser,     // op[2:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata      // found[0], value_out[64:1], status[66:65],
                                           // live_count[77:67], zero[79:78]
);

    localparam int KW  = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int VW  = VALUE_BITS;
    localparam int LE  = LOG_ENTRIES;
    localparam int CA  = LOG_ENTRIES + 1;   // cell address bits
    localparam int CW  = LOG_ENTRIES + 2;   // cell word: tag + entry index
    localparam int NW  = LOG_ENTRIES + 1;   // counter bits
    localparam int NCELLS   = 2 << LOG_ENTRIES;
    localparam int NENTRIES = 1 << LOG_ENTRIES;

    logic [CW-1:0] cell_mem [NCELLS];
    logic [KW-1:0] key_mem  [NENTRIES];
    logic [VW-1:0] val_mem  [NENTRIES];

    t_state r_state, n_state;

    logic [3:0]    r_log, n_log;
    logic [NW-1:0] r_next, n_next;
    logic [NW-1:0] r_active, n_active;
    logic [CA-1:0] r_clr_cnt, n_clr_cnt;
    logic          r_clr_resp, n_clr_resp;
    logic [2:0]    r_op, n_op;
    logic [KW-1:0] r_key, n_key;
    logic [VW-1:0] r_val, n_val;
    logic [CA-1:0] r_probe, n_probe;
    logic [CA-1:0] r_step, n_step;
    logic [CA-1:0] r_mask, n_mask;
    logic          r_found, n_found;
    logic [CA-1:0] r_match_cell, n_match_cell;
    logic [LE-1:0] r_match_ent, n_match_ent;
    logic [CA-1:0] r_empty_cell, n_empty_cell;
    logic [1:0]    r_status, n_status;
    logic          r_vsel, n_vsel;
    logic          r_out_valid, n_out_valid;
    logic [79:0]   r_out_data, n_out_data;

    logic [CW-1:0] r_cell_q;
    logic [KW-1:0] r_key_q;
    logic [VW-1:0] r_val_q;

    logic          cell_we, key_we, val_we;
    logic [CA-1:0] cell_wa;
    logic [CW-1:0] cell_wd;
    logic [LE-1:0] val_wa;
    logic [VW-1:0] val_wd;

    logic [4:0]    lg;
    logic [CA:0]   mask_full;
    logic [CA-1:0] cur_mask;
    logic [NW-1:0] cap;
    logic [31:0]   in_hash;
    logic [31:0]   start_full;
    logic [31:0]   step_full;
    logic          accept;
    logic          out_free;
    logic [CA-1:0] probe_adv;
    logic [1:0]    cell_tag;
    logic [LE-1:0] cell_idx;

    assign lg = (5'(r_log) > 5'(LOG_ENTRIES)) ? 5'(LOG_ENTRIES) : 5'(r_log);
    assign mask_full  = ((CA+1)'(2) << lg) - (CA+1)'(1);
    assign cur_mask   = mask_full[CA-1:0];
    assign cap        = NW'(1) << lg;
    assign in_hash    = s_axis_tdata[63:32];
    assign start_full = in_hash >> (6'd32 - 6'(lg));   // zero when lg is zero
    assign step_full  = {in_hash[30:0], 1'b1};

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign probe_adv = (r_probe + r_step) & r_mask;
    assign cell_tag  = r_cell_q[CW-1 -: 2];
    assign cell_idx  = r_cell_q[LE-1:0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == cur_mask) begin
                    n_state = r_clr_resp ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (s_axis_tuser <= OP_INSERT) begin
                        n_state = S_CELL_RD;
                    end else if (s_axis_tuser == OP_CLEAR) begin
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_CELL_RD: n_state = S_CELL_CHK;
            S_CELL_CHK: begin
                if (cell_tag == TAG_EMPTY) begin
                    n_state = S_ACT;
                end else if (cell_tag == TAG_ENTRY && !r_found) begin
                    n_state = S_KEY_CHK;
                end else begin
                    n_state = S_CELL_RD;
                end
            end
            S_KEY_CHK: n_state = S_CELL_RD;
            S_ACT:     n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) begin
            n_state = S_CLEAR;
        end
    end

    // datapath and memory writes
    always_comb begin
        n_log        = r_log;
        n_next       = r_next;
        n_active     = r_active;
        n_clr_cnt    = r_clr_cnt;
        n_clr_resp   = r_clr_resp;
        n_op         = r_op;
        n_key        = r_key;
        n_val        = r_val;
        n_probe      = r_probe;
        n_step       = r_step;
        n_mask       = r_mask;
        n_found      = r_found;
        n_match_cell = r_match_cell;
        n_match_ent  = r_match_ent;
        n_empty_cell = r_empty_cell;
        n_status     = r_status;
        n_vsel       = r_vsel;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        cell_we      = 1'b0;
        cell_wa      = r_clr_cnt;
        cell_wd      = {TAG_EMPTY, {LE{1'b0}}};
        key_we       = 1'b0;
        val_we       = 1'b0;
        val_wa       = r_match_ent;
        val_wd       = r_val;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                cell_we   = 1'b1;
                n_clr_cnt = r_clr_cnt + CA'(1);
                if (r_clr_cnt == cur_mask) begin
                    n_clr_resp = 1'b0;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op     = s_axis_tuser;
                    n_key    = s_axis_tdata[KW-1:0];
                    n_val    = s_axis_tdata[64 +: VW];
                    n_probe  = start_full[CA-1:0];
                    n_step   = step_full[CA-1:0] & cur_mask;
                    n_mask   = cur_mask;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    n_vsel   = 1'b0;
                    if (s_axis_tuser == OP_CLEAR) begin
                        n_clr_cnt  = '0;
                        n_clr_resp = 1'b1;
                        n_next     = '0;
                        n_active   = '0;
                    end
                end
            end
            S_CELL_CHK: begin
                if (cell_tag == TAG_EMPTY) begin
                    n_empty_cell = r_probe;
                end else if (!(cell_tag == TAG_ENTRY && !r_found)) begin
                    n_probe = probe_adv;
                end
            end
            S_KEY_CHK: begin
                // r_cell_q still holds the cell at r_probe
                if (r_key_q == r_key) begin
                    n_found      = 1'b1;
                    n_match_cell = r_probe;
                    n_match_ent  = cell_idx;
                end
                n_probe = probe_adv;
            end
            S_ACT: begin
                case (r_op)
                    OP_GET: begin
                        n_status = r_found ? ST_OK : ST_NOT_FOUND;
                        n_vsel   = r_found;
                    end
                    OP_DELETE: begin
                        if (r_found) begin
                            cell_we = 1'b1;
                            cell_wa = r_match_cell;
                            cell_wd = {TAG_DELETED, {LE{1'b0}}};
                            if (r_active != '0) begin
                                n_active = r_active - NW'(1);
                            end
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    OP_UPDATE: begin
                        if (r_found) begin
                            val_we = 1'b1;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    OP_SET, OP_INSERT: begin
                        if (r_op == OP_SET && r_found) begin
                            val_we = 1'b1;
                        end else if (r_next >= cap) begin
                            n_status = ST_FULL;
                        end else begin
                            cell_we  = 1'b1;
                            cell_wa  = r_empty_cell;
                            cell_wd  = {TAG_ENTRY, r_next[LE-1:0]};
                            key_we   = 1'b1;
                            val_we   = 1'b1;
                            val_wa   = r_next[LE-1:0];
                            n_next   = r_next + NW'(1);
                            n_active = r_active + NW'(1);
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00, LIVE_W'(r_active), r_status,
                                   r_vsel ? 64'(r_val_q) : 64'd0,
                                   (r_op == OP_CLEAR) ? 1'b0 : r_found};
                end
            end
            default: begin
                n_status = r_status;
            end
        endcase

        if (i_cfg_we) begin
            n_log      = i_cfg_wdata;
            n_clr_cnt  = '0;
            n_clr_resp = 1'b0;
            n_next     = '0;
            n_active   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_log       <= LOG2_SIZE_RESET;
            r_next      <= '0;
            r_active    <= '0;
            r_clr_cnt   <= '0;
            r_clr_resp  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_log       <= n_log;
            r_next      <= n_next;
            r_active    <= n_active;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_resp  <= n_clr_resp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_val        <= n_val;
        r_probe      <= n_probe;
        r_step       <= n_step;
        r_mask       <= n_mask;
        r_found      <= n_found;
        r_match_cell <= n_match_cell;
        r_match_ent  <= n_match_ent;
        r_empty_cell <= n_empty_cell;
        r_status     <= n_status;
        r_vsel       <= n_vsel;
        r_out_data   <= n_out_data;
    end

    // cell RAM: one write, one registered read at the probe address
    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            cell_mem[cell_wa] <= cell_wd;
        end
        r_cell_q <= cell_mem[r_probe];
    end

    // key RAM: read at the entry named by the last cell read
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[r_next[LE-1:0]] <= r_key;
        end
        r_key_q <= key_mem[cell_idx];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            val_mem[val_wa] <= val_wd;
        end
        r_val_q <= val_mem[r_match_ent];
    end

    `DHKV_ASSERT(a_active_le_next, r_active <= r_next)
    `DHKV_ASSERT(a_next_le_cap, (r_state != S_CLEAR) |-> (r_next <= cap))
    `DHKV_ASSERT(a_one_at_a_time, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    `DHKV_ASSERT_ALWAYS(a_reset_idle_out, !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)

endmodule

// ===== test/double_hash_key_value_table_test.sv =====
`timescale 1ns / 100ps

module double_hash_key_value_table_test
    import dhkv_pkg::*;
();

    localparam int N_ENTRIES      = 1 << DEF_LOG_ENTRIES;
    localparam int N_CELLS        = 2 * N_ENTRIES;
    localparam int CELL_EMPTY     = -1;
    localparam int CELL_DELETED   = -2;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int IDLE_PCT       = 29;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 40;
    localparam int N_PHASES       = 20;
    localparam int PHASE_ITEMS    = 86;
    localparam int MAX_POOL       = 48;

    // op codes the block has no meaning for
    localparam logic [2:0] OP_RESERVED_6 = 3'd6;
    localparam logic [2:0] OP_RESERVED_7 = 3'd7;

    typedef enum logic [1:0] {
        ITEM_REQUEST,
        ITEM_RESIZE,
        ITEM_DRAIN
    } t_item_kind;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] key;
        logic [31:0] key_hash;
        logic [63:0] value;
    } t_request;

    typedef struct packed {
        logic        found;
        logic [63:0] value_out;
        logic [1:0]  status;
        logic [10:0] live_count;
    } t_table_result;

    typedef struct {
        t_item_kind kind;
        t_request   rq;
        logic [3:0] size;
        bit         steady;
        bit         rx_hold;
    } t_stim;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [3:0]   i_cfg_wdata = LOG2_SIZE_RESET;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // key[31:0], key_hash[63:32], value[127:64]
    logic [2:0]   s_axis_tuser = '0;   // op[2:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;        // found[0], value_out[64:1], status[66:65],
                                       // live_count[77:67], zero[79:78]

    // shadow of the table
    int          cells [N_CELLS];
    logic [31:0] entry_key [N_ENTRIES];
    logic [63:0] entry_val [N_ENTRIES];
    int          next_slot;
    int          live_entries;
    logic [3:0]  size_reg = LOG2_SIZE_RESET;

    t_stim         pending [$];
    t_table_result expected_results [$];
    t_request      in_flight;

    bit fill_steady;
    bit fill_hold;
    bit steady_now;
    int rx_holds_asked;
    int rx_holds_done;
    int rx_hold_left;
    int settle;
    int cycle_count;
    int errors;
    int requests_sent;
    int results_checked;
    int hits;
    int full_replies;
    int resizes;

    double_hash_key_value_table DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void wipe_table();
        foreach (cells[i]) cells[i] = CELL_EMPTY;
        next_slot = 0;
        live_entries = 0;
    endfunction

    function automatic logic [31:0] mix_hash(logic [31:0] key);
        logic [31:0] h;
        h = key * 32'h9E37_79B1;
        return h ^ (h >> 15) ^ (key << 7);
    endfunction

    // Probe the chain, then apply the op to the shadow table.
    function automatic t_table_result lookup_and_apply(t_request rq);
        t_table_result res;
        int   lg, mask, step, idx, hole, hit_cell, ent, cword, n;
        logic matched, have_hole, done;
        res = '0;
        lg = (size_reg > DEF_LOG_ENTRIES) ? DEF_LOG_ENTRIES : int'(size_reg);
        matched = 1'b0;
        have_hole = 1'b0;
        hole = 0;
        hit_cell = 0;
        if (rq.op <= OP_INSERT) begin
            mask = (2 << lg) - 1;
            step = (2 * rq.key_hash + 1) & mask;
            idx = (lg == 0) ? 0 : int'(rq.key_hash >> (32 - lg));
            done = 1'b0;
            for (n = 0; n <= mask && !done; n++) begin
                cword = cells[idx];
                if (cword == CELL_EMPTY) begin
                    hole = idx;
                    have_hole = 1'b1;
                    done = 1'b1;
                end else begin
                    if (cword != CELL_DELETED && !matched && entry_key[cword] == rq.key) begin
                        matched = 1'b1;
                        hit_cell = idx;
                    end
                    idx = (idx + step) & mask;
                end
            end
        end
        case (rq.op)
            OP_GET, OP_DELETE, OP_UPDATE: begin
                if (!matched) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    ent = cells[hit_cell];
                    if (rq.op == OP_GET) begin
                        res.value_out = entry_val[ent];
                    end else if (rq.op == OP_UPDATE) begin
                        entry_val[ent] = rq.value;
                    end else begin
                        cells[hit_cell] = CELL_DELETED;
                        if (live_entries > 0) live_entries--;
                    end
                end
            end
            OP_SET, OP_INSERT: begin
                // insert-new skips the match and may add a duplicate
                if (rq.op == OP_SET && matched) begin
                    entry_val[cells[hit_cell]] = rq.value;
                end else if (next_slot >= (1 << lg) || !have_hole) begin
                    res.status = ST_FULL;
                end else begin
                    cells[hole] = next_slot;
                    entry_key[next_slot] = rq.key;
                    entry_val[next_slot] = rq.value;
                    next_slot++;
                    live_entries++;
                end
            end
            OP_CLEAR: wipe_table();
            default: ;
        endcase
        res.found = matched;
        res.live_count = 11'(live_entries);
        return res;
    endfunction

    task automatic push_request(logic [2:0] op, logic [31:0] key, logic [31:0] hash,
                                logic [63:0] value);
        t_stim s;
        s.kind = ITEM_REQUEST;
        s.rq = '{op: op, key: key, key_hash: hash, value: value};
        s.size = '0;
        s.steady = fill_steady;
        s.rx_hold = fill_hold;
        pending.push_back(s);
        fill_hold = 1'b0;
    endtask

    task automatic push_control(t_item_kind kind, logic [3:0] size);
        t_stim s;
        s.kind = kind;
        s.rq = '0;
        s.size = size;
        s.steady = 1'b0;
        s.rx_hold = 1'b0;
        pending.push_back(s);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** double_hash_key_value_table: FAILED **");
            $finish;
        end
    end

    // request driver; size writes and pauses wait for the table to go quiet
    always @(posedge i_clk) begin : driver
        logic  offer;
        logic  fire;
        t_stim nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            offer = s_axis_tvalid;
            fire = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(lookup_and_apply(in_flight));
                requests_sent++;
                offer = 1'b0;
            end
            if (!offer && pending.size() != 0) begin
                nxt = pending[0];
                if (nxt.kind == ITEM_REQUEST) begin
                    if (nxt.steady || $urandom_range(0, 99) >= IDLE_PCT) begin
                        void'(pending.pop_front());
                        in_flight = nxt.rq;
                        steady_now = nxt.steady;
                        if (nxt.rx_hold) rx_holds_asked++;
                        s_axis_tdata <= {nxt.rq.value, nxt.rq.key_hash, nxt.rq.key};
                        s_axis_tuser <= nxt.rq.op;
                        offer = 1'b1;
                    end
                end else if (expected_results.size() != 0) begin
                    settle = 0;
                end else if (settle < SETTLE_CYCLES) begin
                    settle++;
                end else begin
                    void'(pending.pop_front());
                    settle = 0;
                    if (nxt.kind == ITEM_RESIZE) begin
                        i_cfg_wdata <= nxt.size;
                        fire = 1'b1;
                        size_reg = nxt.size;
                        wipe_table();
                        resizes++;
                    end
                end
            end
            s_axis_tvalid <= offer;
            i_cfg_we <= fire;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_table_result want;
        logic          ready;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("found", 64'(want.found), 64'(m_axis_tdata[0]));
                    check_field("value_out", want.value_out, m_axis_tdata[64:1]);
                    check_field("status", 64'(want.status), 64'(m_axis_tdata[66:65]));
                    check_field("live_count", 64'(want.live_count),
                                64'(m_axis_tdata[77:67]));
                    results_checked++;
                    if (want.found) hits++;
                    if (want.status == ST_FULL) full_replies++;
                end
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                ready = 1'b0;
            end else if (rx_holds_done != rx_holds_asked) begin
                rx_holds_done++;
                rx_hold_left = RX_HOLD_CYCLES;
                ready = 1'b0;
            end else begin
                ready = steady_now || $urandom_range(0, 99) >= IDLE_PCT;
            end
            m_axis_tready <= ready;
        end
    end

    initial begin
        int          p, i, lg, cap, npool, roll;
        logic [31:0] pool [MAX_POOL];
        logic [31:0] k;
        logic [2:0]  op;
        wipe_table();

        // directed: default size
        push_request(OP_GET, 32'h0, 32'h0, 64'h0);
        push_request(OP_SET, 32'h0, 32'h0, '1);
        push_request(OP_GET, 32'h0, 32'h0, 64'h0);
        push_request(OP_SET, '1, '1, 64'h0);
        push_request(OP_SET, 32'h0, 32'h0, 64'h0123_4567_89AB_CDEF);
        push_request(OP_UPDATE, '1, '1, 64'h5);
        push_request(OP_UPDATE, 32'h1, 32'h8000_0001, 64'h77);
        push_request(OP_INSERT, '1, '1, 64'hA5A5_A5A5_5A5A_5A5A);
        push_request(OP_GET, '1, '1, 64'h0);
        push_request(OP_DELETE, 32'h0, 32'h0, 64'h0);
        push_request(OP_DELETE, 32'h0, 32'h0, 64'h0);
        push_request(OP_GET, 32'h0, 32'h0, 64'h0);
        push_request(OP_RESERVED_6, $urandom, $urandom, {$urandom, $urandom});
        push_request(OP_RESERVED_7, $urandom, $urandom, {$urandom, $urandom});
        push_request(OP_CLEAR, 32'h0, 32'h0, 64'h0);
        push_request(OP_GET, '1, '1, 64'h0);
        // single-entry store: full on the second key, duplicates, no reuse after delete
        push_control(ITEM_RESIZE, 4'd0);
        push_request(OP_SET, 32'h1234_5678, mix_hash(32'h1234_5678), 64'h11);
        push_request(OP_SET, 32'h0BAD_F00D, mix_hash(32'h0BAD_F00D), 64'h22);
        push_request(OP_INSERT, 32'h0000_7777, mix_hash(32'h0000_7777), 64'h33);
        push_request(OP_INSERT, 32'h1234_5678, mix_hash(32'h1234_5678), 64'h44);
        push_request(OP_DELETE, 32'h1234_5678, mix_hash(32'h1234_5678), 64'h0);
        push_request(OP_SET, 32'h1234_5678, mix_hash(32'h1234_5678), 64'h55);
        // out-of-range size saturates
        push_control(ITEM_RESIZE, 4'd15);
        push_request(OP_SET, 32'hDEAD_BEEF, '1, {$urandom, $urandom});
        push_request(OP_GET, 32'hDEAD_BEEF, '1, 64'h0);
        push_request(OP_CLEAR, $urandom, $urandom, {$urandom, $urandom});

        for (p = 0; p < N_PHASES; p++) begin
            if (p == 6) lg = DEF_LOG_ENTRIES;
            else if (p == 14) lg = $urandom_range(11, 15);
            else lg = $urandom_range(1, 6);
            push_control(ITEM_RESIZE, 4'(lg));
            cap = 1 << ((lg > DEF_LOG_ENTRIES) ? DEF_LOG_ENTRIES : lg);
            npool = (cap + 3 > MAX_POOL) ? MAX_POOL : cap + 3;
            for (i = 0; i < npool; i++) pool[i] = $urandom;
            fill_steady = (p == 3);
            fill_hold = (p == 8 || p == 16);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                roll = $urandom_range(0, 99);
                k = pool[$urandom_range(0, npool - 1)];
                if (roll < 24) op = OP_GET;
                else if (roll < 52) op = OP_SET;
                else if (roll < 64) op = OP_DELETE;
                else if (roll < 76) op = OP_UPDATE;
                else if (roll < 86) op = OP_INSERT;
                else if (roll < 89) op = OP_CLEAR;
                else if (roll < 92) op = $urandom_range(0, 1) ? OP_RESERVED_6 : OP_RESERVED_7;
                else op = 3'($urandom_range(0, 7));
                // tail of the range: stray keys and hashes that disagree with the key
                if (roll >= 92)
                    push_request(op, $urandom_range(0, 1) ? k : $urandom, $urandom,
                                 {$urandom, $urandom});
                else
                    push_request(op, k, mix_hash(k), {$urandom, $urandom});
                if (i % 40 == 39) push_control(ITEM_DRAIN, '0);
            end
        end
        fill_steady = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Ran %0d requests across %0d size settings (0 to 15), %0d results checked",
                 requests_sent, resizes + 1, results_checked);
        $display("Key hits: %0d, store-full replies: %0d, long receiver stalls: %0d",
                 hits, full_replies, rx_holds_done);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("** double_hash_key_value_table: PASSED **");
        end else begin
            $display("** double_hash_key_value_table: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/dhkv_pkg.sv
sv/double_hash_key_value_table.sv
test/double_hash_key_value_table_test.sv
